@@ src/tli_pkg.sv @@
// shared types and constants of the table linear interpolator
package tli_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 16;
    localparam int COORD_W             = 32;
    localparam int INDEX_W             = 4;
    localparam int COUNT_W             = 5;
    localparam int CFG_INDEX_W         = 1;
    localparam int CFG_DATA_W          = 5;
    localparam int DIV_STEPS           = 32;
    localparam int DIV_CNT_W           = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0]        POINT_COUNT_RESET = 5'd2;
    localparam logic                      DESCENDING_RESET  = 1'b1;
    localparam logic signed [COORD_W-1:0] Y_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Y_MIN = 32'sh8000_0000;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POINT_COUNT = 1'b0,
        REG_DESCENDING  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_WALK,
        S_MUL,
        S_DIV,
        S_SUM,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                       operation;
        logic [INDEX_W-1:0]        point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] lookup_x;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_y;
        logic                      result_valid;
        logic                      result_clamped;
    } rsp_t;

    // one table entry as it sits in the point memory
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

@@ src/tli_ram.sv @@
// generic single-write, single-read memory with registered read data
module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/table_linear_interpolator_top.sv @@
// table linear interpolator: point table, segment walk, multiply and serial divide
//
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  tli_pkg::req_t (load or lookup transaction)
// rsp       out        rsp_valid/rsp_stall  tli_pkg::rsp_t (one per lookup transaction)
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// a load transaction writes its point in the accept cycle and leaves the sequencer idle
// a lookup reads entry 0 and the last entry through the one memory read port,
//   so a clamped or single-point lookup steps from S_FIRST and S_LAST to S_DONE
// a lookup that interpolates walks one segment per cycle, then passes the 32x32
//   multiplier, the radix-2 divider and the final sum on its way to S_DONE;
//   a zero-width segment skips those and goes from the walk straight to S_DONE
// req_stall is high from a lookup's accept until its result moves into the
//   output register; a stalled result holds the block in its last step
// rst_n clears the sequencer and the output valid and resets the two config registers;
//   the point memory is not cleared and an entry reads undefined until loaded
module table_linear_interpolator_top #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  tli_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output tli_pkg::rsp_t                    rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tli_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tli_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W  = $clog2(TABLE_DEPTH + 1) + tli_pkg::COUNT_W;
    localparam int W      = tli_pkg::COORD_W;

    // control state
    tli_pkg::state_t               state_reg, state_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [tli_pkg::COUNT_W-1:0]   count_reg;
    logic                          desc_reg;

    // datapath state
    logic signed [W-1:0]           x_reg, x_next;
    logic [ADDR_W-1:0]             last_reg, last_next;
    logic [ADDR_W-1:0]             k_reg, k_next;
    tli_pkg::point_t               prev_reg, prev_next;
    logic [W-1:0]                  dxn_reg, dxn_next;
    logic [W-1:0]                  dx_reg, dx_next;
    logic [W-1:0]                  dymag_reg, dymag_next;
    logic                          neg_reg, neg_next;
    logic [2*W-1:0]                pr_reg, pr_next;
    logic [tli_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    tli_pkg::rsp_t                 res_reg, res_next;
    tli_pkg::rsp_t                 rsp_reg, rsp_next;

    // memory port
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [2*W-1:0]                ram_rdata;

    // combinational helpers
    logic                          req_fire;
    logic                          slot_free;
    tli_pkg::point_t               cur;
    logic                          clamp_first;
    logic                          clamp_last;
    logic                          hit;
    logic                          walk_end;
    logic [ADDR_W-1:0]             k_step;
    logic [ADDR_W-1:0]             last_calc;
    logic [W-1:0]                  dx_calc;
    logic [W:0]                    dy_calc;
    logic [W-1:0]                  dymag_calc;
    logic [2*W-1:0]                product;
    logic [W:0]                    trial;
    logic [W:0]                    diff;
    logic signed [W+1:0]           sum;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != tli_pkg::S_IDLE);
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // x and y of one point share a memory word
    tli_ram #(
        .WIDTH (2 * W),
        .DEPTH (TABLE_DEPTH)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({req.point_x, req.point_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur = tli_pkg::point_t'(ram_rdata);

    // last entry in use: a count of zero means one point, a count past the depth saturates
    always_comb
    begin
        if (req.operation == tli_pkg::OP_LOOKUP && count_reg == '0)
        begin
            last_calc = '0;
        end
        else if (CMP_W'(count_reg) > CMP_W'(TABLE_DEPTH))
        begin
            last_calc = ADDR_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_calc = ADDR_W'(count_reg - 1'b1);
        end
    end

    // in the last-entry step prev holds entry 0 and cur the last entry
    assign clamp_first = desc_reg ? (x_reg >= prev_reg.x) : (x_reg <= prev_reg.x);
    assign clamp_last  = desc_reg ? (x_reg <= cur.x) : (x_reg >= cur.x);

    // walk: prev is the low end of the segment, cur the high end, in both orders
    assign hit      = (prev_reg.x <= x_reg) && (x_reg <= cur.x);
    assign walk_end = desc_reg ? (k_reg == '0) : (k_reg == last_reg);
    assign k_step   = desc_reg ? ADDR_W'(k_reg - 1'b1) : ADDR_W'(k_reg + 1'b1);

    // inside a segment x - x_lo and x_hi - x_lo are never negative
    assign dx_calc    = W'(cur.x - prev_reg.x);
    assign dy_calc    = {cur.y[W-1], cur.y} - {prev_reg.y[W-1], prev_reg.y};
    assign dymag_calc = dy_calc[W] ? W'(-dy_calc) : dy_calc[W-1:0];

    assign product = dxn_reg * dymag_reg;

    // restoring divide step; the remainder half stays below the divisor
    assign trial = pr_reg[2*W-1:W-1];
    assign diff  = trial - {1'b0, dx_reg};

    assign sum = neg_reg ? ({{2{prev_reg.y[W-1]}}, prev_reg.y} - {2'b00, pr_reg[W-1:0]})
                         : ({{2{prev_reg.y[W-1]}}, prev_reg.y} + {2'b00, pr_reg[W-1:0]});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tli_pkg::S_IDLE:
            begin
                if (req_fire && req.operation == tli_pkg::OP_LOOKUP)
                begin
                    state_next = tli_pkg::S_FIRST;
                end
            end
            tli_pkg::S_FIRST:
            begin
                state_next = tli_pkg::S_LAST;
            end
            tli_pkg::S_LAST:
            begin
                state_next = (clamp_first || clamp_last) ? tli_pkg::S_DONE : tli_pkg::S_WALK;
            end
            tli_pkg::S_WALK:
            begin
                if (hit)
                begin
                    state_next = (dx_calc == '0) ? tli_pkg::S_DONE : tli_pkg::S_MUL;
                end
                else if (walk_end)
                begin
                    state_next = tli_pkg::S_DONE;
                end
            end
            tli_pkg::S_MUL:
            begin
                state_next = tli_pkg::S_DIV;
            end
            tli_pkg::S_DIV:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = tli_pkg::S_SUM;
                end
            end
            tli_pkg::S_SUM:
            begin
                state_next = tli_pkg::S_DONE;
            end
            tli_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = tli_pkg::S_IDLE;
                end
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        x_next         = x_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        dxn_next       = dxn_reg;
        dx_next        = dx_reg;
        dymag_next     = dymag_reg;
        neg_next       = neg_reg;
        pr_next        = pr_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(req.point_index);
        ram_raddr      = '0;

        unique case (state_reg)
            tli_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.operation == tli_pkg::OP_LOAD)
                    begin
                        // a load past the table is dropped
                        ram_we = (CMP_W'(req.point_index) < CMP_W'(TABLE_DEPTH));
                    end
                    else
                    begin
                        x_next    = req.lookup_x;
                        last_next = last_calc;
                    end
                end
            end
            tli_pkg::S_FIRST:
            begin
                ram_raddr = last_reg;
                prev_next = cur;
            end
            tli_pkg::S_LAST:
            begin
                ram_raddr = desc_reg ? ADDR_W'(last_reg - 1'b1) : ADDR_W'(1);
                k_next    = ram_raddr;
                if (clamp_first)
                begin
                    res_next = '{result_y: prev_reg.y, result_valid: 1'b1, result_clamped: 1'b1};
                end
                else if (clamp_last)
                begin
                    res_next = '{result_y: cur.y, result_valid: 1'b1, result_clamped: 1'b1};
                end
                else if (desc_reg)
                begin
                    prev_next = cur;
                end
            end
            tli_pkg::S_WALK:
            begin
                ram_raddr = k_step;
                if (hit)
                begin
                    dxn_next   = W'(x_reg - prev_reg.x);
                    dx_next    = dx_calc;
                    dymag_next = dymag_calc;
                    neg_next   = dy_calc[W];
                    // zero-width segment gives y_lo
                    res_next   = '{result_y: prev_reg.y, result_valid: 1'b1, result_clamped: 1'b0};
                end
                else if (walk_end)
                begin
                    res_next = '{result_y: '0, result_valid: 1'b0, result_clamped: 1'b0};
                end
                else
                begin
                    prev_next = cur;
                    k_next    = k_step;
                end
            end
            tli_pkg::S_MUL:
            begin
                pr_next  = product;
                cnt_next = '0;
            end
            tli_pkg::S_DIV:
            begin
                if (!diff[W])
                begin
                    pr_next = {diff[W-1:0], pr_reg[W-2:0], 1'b1};
                end
                else
                begin
                    pr_next = {trial[W-1:0], pr_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            tli_pkg::S_SUM:
            begin
                res_next.result_valid   = 1'b1;
                res_next.result_clamped = 1'b0;
                if (sum > (W+2)'(tli_pkg::Y_MAX))
                begin
                    res_next.result_y = tli_pkg::Y_MAX;
                end
                else if (sum < (W+2)'(tli_pkg::Y_MIN))
                begin
                    res_next.result_y = tli_pkg::Y_MIN;
                end
                else
                begin
                    res_next.result_y = sum[W-1:0];
                end
            end
            tli_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tli_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= tli_pkg::POINT_COUNT_RESET;
            desc_reg      <= tli_pkg::DESCENDING_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (tli_pkg::cfg_reg_t'(cfg_index))
                    tli_pkg::REG_POINT_COUNT: count_reg <= cfg_data;
                    tli_pkg::REG_DESCENDING:  desc_reg  <= cfg_data[0];
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        last_reg  <= last_next;
        k_reg     <= k_next;
        prev_reg  <= prev_next;
        dxn_reg   <= dxn_next;
        dx_reg    <= dx_next;
        dymag_reg <= dymag_next;
        neg_reg   <= neg_next;
        pr_reg    <= pr_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    // a lookup transaction always starts the table read
    a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.operation == tli_pkg::OP_LOOKUP |=> state_reg == tli_pkg::S_FIRST)
        else $error("lookup did not start the table read");

    // a load transaction never occupies the sequencer
    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.operation == tli_pkg::OP_LOAD |=> state_reg == tli_pkg::S_IDLE)
        else $error("load left the sequencer busy");

    // partial remainder stays below the divisor, so the quotient fits 32 bits
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tli_pkg::S_DIV |-> pr_reg[2*W-1:W] < dx_reg)
        else $error("divider remainder out of range");

    // divider runs its full count before the final sum
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tli_pkg::S_DIV && cnt_reg == '1 |=> state_reg == tli_pkg::S_SUM)
        else $error("divider left early or late");

    // clamped results are valid, invalid results carry zero
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.result_valid || (!rsp.result_clamped && rsp.result_y == '0)))
        else $error("inconsistent result flags");

endmodule
